// ===== hdl/c33_pkg.sv =====
// Shared types, constants and register codes of the 3x3 convolution block.
`timescale 1ns / 1ps
package c33_pkg;
	localparam int PIX_W        = 8;
	localparam int COORD_W      = 10;
	localparam int SIZE_REG_W   = 11;
	localparam int KREG_W       = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int SIZE_W       = 13;   // holds sizes up to 4096
	localparam int DEF_MAX_ROWS = 1024;
	localparam int DEF_MAX_COLS = 1024;

	localparam logic [SIZE_REG_W-1:0] RST_ROWS = 11'd1024;
	localparam logic [SIZE_REG_W-1:0] RST_COLS = 11'd1024;
	localparam logic [KREG_W-1:0] RST_KROW0 = 24'hFF0001;
	localparam logic [KREG_W-1:0] RST_KROW1 = 24'hFE0002;
	localparam logic [KREG_W-1:0] RST_KROW2 = 24'hFF0001;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS  = 3'd0,
		REG_COLS  = 3'd1,
		REG_KROW0 = 3'd2,
		REG_KROW1 = 3'd3,
		REG_KROW2 = 3'd4
	} cfg_reg_t;

	// one window column: [0] two rows up, [1] one row up, [2] current row
	typedef logic [2:0][PIX_W-1:0] pcol_t;

	typedef struct packed {
		logic en;
		logic restart;
	} cell_ctl_t;
endpackage

// ===== hdl/c33_line_ram.sv =====
// Single line store: one write port, one registered read port.
`timescale 1ns / 1ps
module c33_line_ram #(
	parameter int DEPTH = c33_pkg::DEF_MAX_COLS,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [c33_pkg::PIX_W-1:0]  wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [c33_pkg::PIX_W-1:0]  rdata
);
	logic [c33_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/c33_col_cell.sv =====
// Window column cell: takes its right neighbor's column or a fresh one.
`timescale 1ns / 1ps
module c33_col_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  c33_pkg::cell_ctl_t ctl,
	input  c33_pkg::pcol_t     nbr,
	input  c33_pkg::pcol_t     fresh,
	output c33_pkg::pcol_t     col
);
	c33_pkg::pcol_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.en) begin
			col_q <= ctl.restart ? fresh : nbr;
		end
	end

	assign col = col_q;
endmodule

// ===== hdl/conv3x3_replicate_edges.sv =====
// Top level: streaming 3x3 convolution with edge replication.
// Pipeline: line store reads, result select, then product operand, product and sum registers.
// One request per cycle while the output does not stall; result select sends one result at a time,
// so a request completing several results holds off input until all but its last are sent.
// Reset (arst_n low): counters, window cells and valids clear, configuration
// registers load their reset values; line stores are not cleared.
`timescale 1ns / 1ps
module conv3x3_replicate_edges #(
	parameter int MAX_ROWS = c33_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = c33_pkg::DEF_MAX_COLS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [c33_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [c33_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel requests
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel_in
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,   // [7:0] pixel_out,
	                                                          // [17:8] out_row,
	                                                          // [27:18] out_col
	output logic                              m_axis_tlast,   // last_of_burst
	output logic                              m_axis_tuser    // [0] last_of_image
);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SW = c33_pkg::SIZE_W;
	localparam int PW = c33_pkg::PIX_W;
	localparam int OW = c33_pkg::COORD_W;
	localparam logic [SW-1:0] MAXR = SW'(MAX_ROWS);
	localparam logic [SW-1:0] MAXC = SW'(MAX_COLS);

	// ---------------- configuration registers ----------------
	logic [c33_pkg::SIZE_REG_W-1:0] rows_q, cols_q;
	logic [2:0][c33_pkg::KREG_W-1:0] kern_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= c33_pkg::RST_ROWS;
			cols_q    <= c33_pkg::RST_COLS;
			kern_q[0] <= c33_pkg::RST_KROW0;
			kern_q[1] <= c33_pkg::RST_KROW1;
			kern_q[2] <= c33_pkg::RST_KROW2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				c33_pkg::REG_ROWS:  rows_q    <= cfg_data[c33_pkg::SIZE_REG_W-1:0];
				c33_pkg::REG_COLS:  cols_q    <= cfg_data[c33_pkg::SIZE_REG_W-1:0];
				c33_pkg::REG_KROW0: kern_q[0] <= cfg_data[c33_pkg::KREG_W-1:0];
				c33_pkg::REG_KROW1: kern_q[1] <= cfg_data[c33_pkg::KREG_W-1:0];
				c33_pkg::REG_KROW2: kern_q[2] <= cfg_data[c33_pkg::KREG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective size: zero acts as one, clipped to the build maximum
	logic [SW-1:0] rows_ext, cols_ext, r_lim, c_lim;
	assign rows_ext = SW'(rows_q);
	assign cols_ext = SW'(cols_q);
	assign r_lim = (rows_ext == '0) ? SW'(1) : ((rows_ext > MAXR) ? MAXR : rows_ext);
	assign c_lim = (cols_ext == '0) ? SW'(1) : ((cols_ext > MAXC) ? MAXC : cols_ext);

	// ---------------- handshake chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic acc, a_adv, b_done, b_send, s3_free, s4_free, s5_free;
	logic [3:0] e_s2, sel;

	assign s5_free = !v_s5 || m_axis_tready;
	assign s4_free = !v_s4 || s5_free;
	assign s3_free = !v_s3 || s4_free;
	assign b_send  = v_s2 && (e_s2 != '0) && s3_free;
	assign b_done  = v_s2 && ((e_s2 == '0) || (s3_free && ((e_s2 & ~sel) == '0)));
	assign a_adv   = v_s1 && (!v_s2 || b_done);
	assign s_axis_tready = !v_s1 || a_adv;
	assign acc     = s_axis_tvalid && s_axis_tready;

	// ---------------- position counters ----------------
	logic [RW-1:0] row_q, r_pre;
	logic [CW-1:0] col_q, c_pre;
	logic [SW-1:0] r_tmp;
	logic lcol_c, lrow_c;

	always_comb begin
		r_tmp = SW'(row_q);
		c_pre = col_q;
		if (SW'(col_q) >= c_lim) begin
			c_pre = '0;
			r_tmp = SW'(row_q) + SW'(1);
		end
		if (r_tmp >= r_lim) begin
			r_tmp = '0;
		end
		r_pre  = r_tmp[RW-1:0];
		lcol_c = (SW'(c_pre) == c_lim - SW'(1));
		lrow_c = (SW'(r_pre) == r_lim - SW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (SW'(c_pre) >= c_lim - SW'(1)) begin
				col_q <= '0;
				row_q <= (SW'(r_pre) >= r_lim - SW'(1)) ? '0 : r_pre + RW'(1);
			end else begin
				col_q <= c_pre + CW'(1);
			end
		end
	end

	// ---------------- stage 1: line store reads ----------------
	logic [PW-1:0] pix_s1, fcur_s1, fmid_s1, rd_mid, rd_top;
	logic [RW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic lcol_s1, lrow_s1, fwd_s1;
	logic [PW-1:0] mem_mid, mem_top, mid_c, top_c;

	// a write and a read of the same column at one edge (single-column
	// images) return stale data, so the written values are forwarded
	assign mem_mid = fwd_s1 ? fcur_s1 : rd_mid;
	assign mem_top = fwd_s1 ? fmid_s1 : rd_top;
	assign mid_c   = (r_s1 != '0) ? mem_mid : pix_s1;
	assign top_c   = (r_s1 > RW'(1)) ? mem_top : mid_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (acc) begin
			v_s1   <= 1'b1;
			fwd_s1 <= a_adv && (c_s1 == c_pre);
		end else if (a_adv) begin
			v_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= s_axis_tdata;
			r_s1    <= r_pre;
			c_s1    <= c_pre;
			lcol_s1 <= lcol_c;
			lrow_s1 <= lrow_c;
			fcur_s1 <= pix_s1;
			fmid_s1 <= mid_c;
		end
	end

	c33_line_ram #(.DEPTH(MAX_COLS), .AW(CW)) u_line_mid (
		.clk(clk), .we(a_adv), .waddr(c_s1), .wdata(pix_s1),
		.re(acc), .raddr(c_pre), .rdata(rd_mid)
	);

	c33_line_ram #(.DEPTH(MAX_COLS), .AW(CW)) u_line_top (
		.clk(clk), .we(a_adv), .waddr(c_s1), .wdata(mid_c),
		.re(acc), .raddr(c_pre), .rdata(rd_top)
	);

	// ---------------- window: chain of three column cells ----------------
	c33_pkg::pcol_t fresh;
	c33_pkg::pcol_t wcol [3];
	c33_pkg::cell_ctl_t cctl;

	assign fresh[0] = top_c;
	assign fresh[1] = mid_c;
	assign fresh[2] = pix_s1;
	assign cctl.en      = a_adv;
	assign cctl.restart = (c_s1 == '0);  // row start fills the whole window

	c33_col_cell u_cell0 (.clk(clk), .arst_n(arst_n), .ctl(cctl), .nbr(wcol[1]),
		.fresh(fresh), .col(wcol[0]));
	c33_col_cell u_cell1 (.clk(clk), .arst_n(arst_n), .ctl(cctl), .nbr(wcol[2]),
		.fresh(fresh), .col(wcol[1]));
	c33_col_cell u_cell2 (.clk(clk), .arst_n(arst_n), .ctl(cctl), .nbr(fresh),
		.fresh(fresh), .col(wcol[2]));

	// ---------------- stage 2: result select ----------------
	// e bits in emission order: inner column row above, inner column last
	// row, edge column row above, edge column last row
	logic [RW-1:0] r_s2;
	logic [CW-1:0] c_s2;
	logic [3:0] e_c;
	logic vlast, hedge;
	logic [8:0][PW-1:0] px_c;

	assign e_c[0] = (c_s1 != '0) && (r_s1 != '0);
	assign e_c[1] = (c_s1 != '0) && lrow_s1;
	assign e_c[2] = lcol_s1 && (r_s1 != '0);
	assign e_c[3] = lcol_s1 && lrow_s1;

	assign sel   = e_s2 & (~e_s2 + 4'd1);
	assign vlast = sel[1] | sel[3];
	assign hedge = sel[2] | sel[3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				// bottom edge repeats the current row, right edge the newest column
				px_c[i*3+j] = wcol[(hedge ? ((j == 0) ? 1 : 2) : j)]
				                  [(vlast ? ((i == 0) ? 1 : 2) : i)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			e_s2 <= '0;
		end else if (a_adv) begin
			v_s2 <= 1'b1;
			e_s2 <= e_c;
		end else begin
			if (b_done) begin
				v_s2 <= 1'b0;
			end
			if (b_send) begin
				e_s2 <= e_s2 & ~sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_adv) begin
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	// ---------------- stages 3-5: products and sum ----------------
	logic [8:0][PW-1:0] px_s3, prod_s4;
	logic [OW-1:0] row_s3, col_s3, row_s4, col_s4, row_s5, col_s5;
	logic lb_s3, li_s3, lb_s4, li_s4, lb_s5, li_s5;
	logic [PW-1:0] sum_c, sum_s5;
	logic [2*PW-1:0] prod_c [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (s3_free) v_s3 <= b_send;
			if (s4_free) v_s4 <= v_s3;
			if (s5_free) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (b_send && s3_free) begin
			px_s3  <= px_c;
			row_s3 <= OW'(vlast ? r_s2 : r_s2 - RW'(1));
			col_s3 <= OW'(hedge ? c_s2 : c_s2 - CW'(1));
			lb_s3  <= ((e_s2 & ~sel) == '0);
			li_s3  <= sel[3];
		end
	end

	// only the low byte of the sum is kept, so low product bytes suffice
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			prod_c[k] = kern_q[k/3][(k%3)*PW +: PW] * px_s3[k];
		end
		sum_c = '0;
		for (int k = 0; k < 9; k++) begin
			sum_c = sum_c + prod_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && s4_free) begin
			for (int k = 0; k < 9; k++) begin
				prod_s4[k] <= prod_c[k][PW-1:0];
			end
			row_s4 <= row_s3;
			col_s4 <= col_s3;
			lb_s4  <= lb_s3;
			li_s4  <= li_s3;
		end
		if (v_s4 && s5_free) begin
			sum_s5 <= sum_c;
			row_s5 <= row_s4;
			col_s5 <= col_s4;
			lb_s5  <= lb_s4;
			li_s5  <= li_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {4'd0, col_s5, row_s5, sum_s5};
	assign m_axis_tlast  = lb_s5;
	assign m_axis_tuser  = li_s5;
endmodule

// ===== hdl/c33_check.sv =====
// Port checker for the convolution block, bound to the top level.
`timescale 1ns / 1ps
module c33_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);
	// a stalled result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// the image's final result always closes its burst
	a_img_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("last_of_image without last_of_burst");

	// pad bits above the column field are clear on the image's final result
	a_img_diag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:28] == 4'd0)
		else $error("pad bits set");

	// no result right after reset
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid after reset");
endmodule

bind conv3x3_replicate_edges c33_check u_c33_check (.*);
